### rtl/gtfc_pkg.sv
// shared types, stage numbering and constants for the gtf mode timing calculator
package gtfc_pkg;

    // pipeline stage numbering
    localparam int NSTAGE     = 26;
    localparam int S_PRE      = 0;   // blanking fraction terms
    localparam int S_DIV1_END = 10;  // stages 1..10: vertical blank quotient, one bit each
    localparam int S_VTOT     = 11;  // vertical total and line rate
    localparam int S_DUTY     = 12;  // duty numerator and denominator
    localparam int S_NUM      = 13;  // horizontal blank dividend
    localparam int S_SIGN     = 14;  // negative dividend handling
    localparam int S_DIV2_END = 21;  // stages 15..21: blank quotient, one bit each
    localparam int S_HPOS     = 22;  // horizontal positions
    localparam int S_MUL      = 23;  // pixel clock partial products
    localparam int S_SCALE    = 24;  // reciprocal scaling
    localparam int S_PCLK     = 25;  // pixel clock sum, output register

    // formula constants
    localparam int VB_BASE   = 20000;
    localparam int VB_FACTOR = 11;
    localparam int DUTY_HI   = 30000;
    localparam int DUTY_A    = 3;
    localparam int DUTY_B    = 7;
    localparam int HS_ROUND  = 50;
    localparam int HS_MUL    = 8;
    localparam int VS_LEN    = 3;
    localparam int KHZ_DIV   = 1000;

    // reciprocals: v / 1000 for v < 2^21, n / 1000 for n < 2^23, n / 100 for n < 2^13
    localparam int RCP_1000_V   = 2147484;
    localparam int RCP_1000_V_S = 31;
    localparam int RCP_1000_L   = 8589935;
    localparam int RCP_1000_L_S = 33;
    localparam int RCP_100      = 5243;
    localparam int RCP_100_S    = 19;

    typedef logic [4:0] t_stage;

    // one item as it moves down the pipeline
    typedef struct packed {
        logic [11:0]        x;
        logic [11:0]        y;
        logic [7:0]         f;
        logic [24:0]        num1;     // dividend, then partial remainder
        logic [15:0]        den1;
        logic [9:0]         q1;
        logic [12:0]        vbl;
        logic [20:0]        v;
        logic signed [22:0] n;
        logic [23:0]        d;
        logic [10:0]        vh;
        logic [9:0]         vl;
        logic signed [35:0] num2;
        logic [28:0]        den2;
        logic [34:0]        rem2;
        logic [6:0]         k;
        logic               clamp;
        logic [12:0]        tot;
        logic [15:0]        hs_end;
        logic [15:0]        hbl_last;
        logic [23:0]        p_hi;
        logic [22:0]        p_lo;
        logic [24:0]        c100;
        logic [12:0]        lo_q;
        logic [15:0]        hs_begin;
        logic [22:0]        pix;
    } t_item;

    // per-stage flow control
    typedef struct packed {
        logic [NSTAGE-1:0] en;
        logic [NSTAGE-1:0] vld;
    } t_flow;

endpackage

### rtl/gtfc_flow.sv
// valid bits and per-stage load enables for the timing pipeline
module gtfc_flow (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_stall,
    output gtfc_pkg::t_flow o_flow
);

    logic [gtfc_pkg::NSTAGE-1:0] r_vld;
    logic [gtfc_pkg::NSTAGE-1:0] n_vld;
    logic [gtfc_pkg::NSTAGE-1:0] en;

    // a stage loads when empty or when the next one moves
    always_comb begin
        en[gtfc_pkg::NSTAGE-1] = !r_vld[gtfc_pkg::NSTAGE-1] || !i_stall;
        for (int s = gtfc_pkg::NSTAGE - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    // valid bits follow the data
    always_comb begin
        for (int s = 0; s < gtfc_pkg::NSTAGE; s++) begin
            if (!en[s]) begin
                n_vld[s] = r_vld[s];
            end else if (s == 0) begin
                n_vld[s] = i_valid;
            end else begin
                n_vld[s] = r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_flow.en  = en;
    assign o_flow.vld = r_vld;

`ifndef SYNTHESIS
    // input only stalls when every stage holds an item
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en[0] |-> &r_vld)
        else $error("input stalled with a bubble in the pipeline");

    // an accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && en[0]) |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

    // with no output stall the whole pipeline moves
    a_free_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> &en)
        else $error("stage held without output stall");

    // a stalled result is kept
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[gtfc_pkg::NSTAGE-1] && i_stall) |=> r_vld[gtfc_pkg::NSTAGE-1])
        else $error("stalled result dropped");
`endif

endmodule

### rtl/gtf_mode_timing_calc_core.sv
// top level of the gtf mode timing calculator: 26-stage timing pipeline
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_stall    i_active_width, i_active_height, i_refresh_hz
//  output   out        o_valid / i_stall    o_pixel_clock_khz, o_h_sync_*, o_h_blank_last,
//                                           o_v_sync_*, o_v_blank_last, o_blank_clamped
//
// one item per cycle while the output does not stall; an item passes 26 stages, a depth
// set by the two bit-per-stage dividers (10 and 7 stages) and the multiply stages
// reset clears only the stage valid bits; the pipeline is empty after reset
// an output stall holds the last stage and fills bubbles behind it; input stalls
// only when all 26 stages hold an item
module gtf_mode_timing_calc_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_active_width,
    input  logic [11:0] i_active_height,
    input  logic [7:0]  i_refresh_hz,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [22:0] o_pixel_clock_khz,
    output logic [15:0] o_h_sync_begin,
    output logic [15:0] o_h_sync_finish,
    output logic [15:0] o_h_blank_last,
    output logic [11:0] o_v_sync_begin,
    output logic [12:0] o_v_sync_finish,
    output logic [15:0] o_v_blank_last,
    output logic        o_blank_clamped
);

    gtfc_pkg::t_flow flow;
    gtfc_pkg::t_item r_pipe [gtfc_pkg::NSTAGE];
    gtfc_pkg::t_item n_pipe [gtfc_pkg::NSTAGE];
    gtfc_pkg::t_item last;

    // work of one stage
    function automatic gtfc_pkg::t_item step(input gtfc_pkg::t_stage s,
                                             input gtfc_pkg::t_item it);
        gtfc_pkg::t_item    o;
        logic [14:0]        a;
        logic [3:0]         b;
        logic [25:0]        sh1;
        logic [35:0]        sh2;
        logic [42:0]        mv;
        logic [46:0]        ml;
        logic signed [35:0] xs;
        o   = it;
        a   = '0;
        b   = '0;
        sh1 = '0;
        sh2 = '0;
        mv  = '0;
        ml  = '0;
        xs  = '0;
        if (s == 5'(gtfc_pkg::S_PRE)) begin
            // blanking fraction dividend and divisor
            a      = 15'(gtfc_pkg::VB_BASE) - 15'(gtfc_pkg::VB_FACTOR) * 15'(it.f);
            o.den1 = {a, 1'b0};
            o.num1 = 25'(a) * 25'd3
                   + 25'(it.f) * 25'({1'b0, it.y} + 13'd1) * 25'(2 * gtfc_pkg::VB_FACTOR);
            o.q1   = '0;
        end else if (s <= 5'(gtfc_pkg::S_DIV1_END)) begin
            // restoring divide, one quotient bit
            b   = 4'(gtfc_pkg::S_DIV1_END - int'(s));
            sh1 = 26'(it.den1) << b;
            if ({1'b0, it.num1} >= sh1) begin
                o.num1  = it.num1 - sh1[24:0];
                o.q1[b] = 1'b1;
            end
        end else if (s == 5'(gtfc_pkg::S_VTOT)) begin
            // vertical total and line rate
            o.vbl = 13'(it.y) + 13'(it.q1);
            o.v   = 21'(13'(it.y) + 13'(it.q1)) * 21'(it.f);
        end else if (s == 5'(gtfc_pkg::S_DUTY)) begin
            // duty terms and line rate in thousands
            o.n  = 23'(signed'({2'b0, it.v})) * 23'(gtfc_pkg::DUTY_A)
                 - 23'(gtfc_pkg::DUTY_HI);
            o.d  = 24'(it.v) * 24'(gtfc_pkg::DUTY_B) + 24'(gtfc_pkg::DUTY_HI);
            mv   = 43'(it.v) * 43'(gtfc_pkg::RCP_1000_V);
            o.vh = 11'(mv >> gtfc_pkg::RCP_1000_V_S);
        end else if (s == 5'(gtfc_pkg::S_NUM)) begin
            // blank dividend, divisor and line rate remainder
            xs     = signed'(36'(it.x));
            o.num2 = 36'sd2 * xs * 36'(it.n) + signed'(36'({it.d, 4'b0}));
            o.den2 = {it.d, 5'b0};
            o.vl   = 10'(it.v - 21'(it.vh) * 21'(gtfc_pkg::KHZ_DIV));
        end else if (s == 5'(gtfc_pkg::S_SIGN)) begin
            // negative blank: zero, flag when at or below minus one
            o.k     = '0;
            o.rem2  = it.num2[35] ? '0 : it.num2[34:0];
            o.clamp = it.num2[35] && ((it.num2 + signed'(36'(it.den2))) <= 36'sd0);
        end else if (s <= 5'(gtfc_pkg::S_DIV2_END)) begin
            // restoring divide, one quotient bit
            b   = 4'(gtfc_pkg::S_DIV2_END - int'(s));
            sh2 = 36'(it.den2) << b;
            if ({1'b0, it.rem2} >= sh2) begin
                o.rem2       = it.rem2 - sh2[34:0];
                o.k[b[2:0]]  = 1'b1;
            end
        end else if (s == 5'(gtfc_pkg::S_HPOS)) begin
            // horizontal total and positions
            o.tot      = 13'(it.x) + 13'({it.k, 4'b0});
            o.hs_end   = 16'(it.x) + 16'(it.k) * 16'(gtfc_pkg::HS_MUL) - 16'd1;
            o.hbl_last = 16'(13'(it.x) + 13'({it.k, 4'b0})) - 16'd1;
        end else if (s == 5'(gtfc_pkg::S_MUL)) begin
            // pixel clock partial products and sync rounding product
            o.p_hi = 24'(it.tot) * 24'(it.vh);
            o.p_lo = 23'(it.tot) * 23'(it.vl);
            o.c100 = 25'(it.tot + 13'(gtfc_pkg::HS_ROUND)) * 25'(gtfc_pkg::RCP_100);
        end else if (s == 5'(gtfc_pkg::S_SCALE)) begin
            // remainder part over 1000, sync start
            ml         = 47'(it.p_lo) * 47'(gtfc_pkg::RCP_1000_L);
            o.lo_q     = 13'(ml >> gtfc_pkg::RCP_1000_L_S);
            o.hs_begin = it.hs_end
                       - 16'(it.c100 >> gtfc_pkg::RCP_100_S) * 16'(gtfc_pkg::HS_MUL);
        end else begin
            // pixel clock in khz
            o.pix = 23'(it.p_hi + 24'(it.lo_q));
        end
        return o;
    endfunction

    gtfc_flow u_flow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_flow  (flow)
    );

    // next value of every stage
    always_comb begin
        gtfc_pkg::t_item src;
        for (int s = 0; s < gtfc_pkg::NSTAGE; s++) begin
            if (s == 0) begin
                src   = '0;
                src.x = i_active_width;
                src.y = i_active_height;
                src.f = i_refresh_hz;
            end else begin
                src = r_pipe[s-1];
            end
            n_pipe[s] = step(5'(s), src);
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < gtfc_pkg::NSTAGE; s++) begin
            if (flow.en[s]) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
    end

    // outputs from the last stage
    assign last              = r_pipe[gtfc_pkg::NSTAGE-1];
    assign o_stall           = !flow.en[0];
    assign o_valid           = flow.vld[gtfc_pkg::NSTAGE-1];
    assign o_pixel_clock_khz = last.pix;
    assign o_h_sync_begin    = last.hs_begin;
    assign o_h_sync_finish   = last.hs_end;
    assign o_h_blank_last    = last.hbl_last;
    assign o_v_sync_begin    = last.y;
    assign o_v_sync_finish   = 13'(last.y) + 13'(gtfc_pkg::VS_LEN);
    assign o_v_blank_last    = 16'(last.vbl) - 16'd1;
    assign o_blank_clamped   = last.clamp;

endmodule

### test/tb_gtf_mode_timing_calc_core.sv
// testbench for the gtf mode timing calculator: directed table, random items, scoreboard
`timescale 1ns / 100ps

module tb_gtf_mode_timing_calc_core;

    // one expected timing set
    typedef struct {
        logic [22:0] pclk;
        logic [15:0] hs_begin;
        logic [15:0] hs_finish;
        logic [15:0] hblank_last;
        logic [11:0] vs_begin;
        logic [12:0] vs_finish;
        logic [15:0] vblank_last;
        logic        clamped;
    } t_timing;

    // one directed row: inputs, plus an optional typed-in result
    typedef struct {
        logic [11:0] w;
        logic [11:0] h;
        logic [7:0]  r;
        bit          typed;
        t_timing     res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [11:0] i_active_width;
    logic [11:0] i_active_height;
    logic [7:0]  i_refresh_hz;
    logic        o_valid;
    logic        i_stall;
    logic [22:0] o_pixel_clock_khz;
    logic [15:0] o_h_sync_begin;
    logic [15:0] o_h_sync_finish;
    logic [15:0] o_h_blank_last;
    logic [11:0] o_v_sync_begin;
    logic [12:0] o_v_sync_finish;
    logic [15:0] o_v_blank_last;
    logic        o_blank_clamped;

    t_timing     timing_queue[$];
    t_timing     typed_queue[$];
    bit          typed_flag_queue[$];
    int          errors;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    localparam int LIMIT = 400000;

    gtf_mode_timing_calc_core dut (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // timing predictor, exact integer rationals
    function automatic t_timing gtf_timing(logic [11:0] x, logic [11:0] y, logic [7:0] f);
        t_timing     t;
        longint      a, vbl, v, n, d, num, den, k, hbl, hs_end;
        a   = 20000 - 11 * longint'(f);
        vbl = y + (3 * a + 22 * longint'(f) * (longint'(y) + 1)) / (2 * a);
        v   = vbl * f;
        n   = 3 * v - 30000;
        d   = 7 * v + 30000;
        num = 2 * longint'(x) * n + 16 * d;
        den = 32 * d;
        k   = 0;
        t.clamped = 1'b0;
        if (num >= 0)
            k = num / den;
        else if (num <= -den)
            t.clamped = 1'b1;
        hbl    = 16 * k;
        hs_end = x + hbl / 2 - 1;
        t.pclk        = 23'(((x + hbl) * v) / 1000);
        t.hs_finish   = 16'(hs_end);
        t.hs_begin    = 16'(hs_end - ((x + hbl + 50) / 100) * 8);
        t.hblank_last = 16'(x + hbl - 1);
        t.vs_begin    = y;
        t.vs_finish   = 13'(y + 3);
        t.vblank_last = 16'(vbl - 1);
        return t;
    endfunction

    // hand one item to the block and wait for its acceptance
    task automatic send_item(logic [11:0] w, logic [11:0] h, logic [7:0] r,
                             bit typed, t_timing res);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_active_width  <= w;
        i_active_height <= h;
        i_refresh_hz    <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        timing_queue.push_back(gtf_timing(w, h, r));
        typed_flag_queue.push_back(typed);
        typed_queue.push_back(res);
    endtask

    // random stall on the result side
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // compare one field
    task automatic check_field(string name, longint got, longint want);
        if (got != want) begin
            errors++;
            $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, want, got);
        end
    endtask

    // result checking against the oldest expectation
    always @(posedge i_clk) begin
        t_timing e;
        t_timing tp;
        bit      ty;
        if (i_rst_n && o_valid && !i_stall) begin
            if (timing_queue.size() == 0) begin
                errors++;
                $display("%0t mismatch unexpected item expected none actual pclk %0d",
                         $realtime, o_pixel_clock_khz);
            end else begin
                e  = timing_queue.pop_front();
                tp = typed_queue.pop_front();
                ty = typed_flag_queue.pop_front();
                // typed-in rows must also agree with the hand-written values
                if (ty) begin
                    check_field("typed pclk", e.pclk, tp.pclk);
                    check_field("typed hblank_last", e.hblank_last, tp.hblank_last);
                    check_field("typed clamped", e.clamped, tp.clamped);
                end
                check_field("pixel_clock_khz", o_pixel_clock_khz, e.pclk);
                check_field("h_sync_begin", o_h_sync_begin, e.hs_begin);
                check_field("h_sync_finish", o_h_sync_finish, e.hs_finish);
                check_field("h_blank_last", o_h_blank_last, e.hblank_last);
                check_field("v_sync_begin", o_v_sync_begin, e.vs_begin);
                check_field("v_sync_finish", o_v_sync_finish, e.vs_finish);
                check_field("v_blank_last", o_v_blank_last, e.vblank_last);
                check_field("blank_clamped", o_blank_clamped, e.clamped);
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row    rows[$];
        t_row    rw;
        t_timing z;
        int      drain;
        errors  = 0;
        cycles  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_active_width  = '0;
        i_active_height = '0;
        i_refresh_hz    = '0;
        z = '{default: '0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: typed results for zero rate and zero width rows
        rw = '{w: 0, h: 0, r: 0, typed: 1, res: z};
        rw.res.hblank_last = 16'hFFFF;
        rows.push_back(rw);
        rw = '{w: 0, h: 480, r: 60, typed: 1, res: z};
        rw.res.hblank_last = 16'hFFFF;
        rows.push_back(rw);
        rw = '{w: 4095, h: 4095, r: 255, typed: 0, res: z};
        rows.push_back(rw);
        rw = '{w: 4095, h: 1, r: 24, typed: 0, res: z};
        rows.push_back(rw);
        rw = '{w: 1, h: 4095, r: 240, typed: 0, res: z};
        rows.push_back(rw);
        rw = '{w: 640, h: 480, r: 60, typed: 0, res: z};
        rows.push_back(rw);
        rw = '{w: 1920, h: 1080, r: 60, typed: 0, res: z};
        rows.push_back(rw);
        rw = '{w: 4095, h: 1, r: 1, typed: 0, res: z};   // negative blank, flagged
        rows.push_back(rw);
        rw = '{w: 4095, h: 0, r: 1, typed: 0, res: z};
        rows.push_back(rw);
        rw = '{w: 16, h: 1, r: 1, typed: 0, res: z};     // small negative t, not flagged
        rows.push_back(rw);
        rw = '{w: 2730, h: 2730, r: 170, typed: 0, res: z};
        rows.push_back(rw);
        rw = '{w: 1365, h: 1365, r: 85, typed: 0, res: z};
        rows.push_back(rw);
        rw = '{w: 800, h: 0, r: 120, typed: 0, res: z};
        rows.push_back(rw);
        foreach (rows[i])
            send_item(rows[i].w, rows[i].h, rows[i].r, rows[i].typed, rows[i].res);

        // random phases with different idling
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                3: begin send_idle_pct = 12; recv_stall_pct = 12; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < 150; i++) begin
                case ($urandom_range(4))
                    0: send_item(12'($urandom), 12'($urandom), 8'($urandom), 1'b0, z);
                    1: send_item(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                                 8'($urandom_range(15)), 1'b0, z);
                    default: send_item(12'($urandom_range(1, 4095)),
                                       12'($urandom_range(1, 4095)),
                                       8'($urandom_range(24, 240)), 1'b0, z);
                endcase
            end
        end
        i_valid <= 1'b0;
        recv_stall_pct = 30;

        // drain
        while (timing_queue.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 40) begin
            @(posedge i_clk);
            drain++;
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/gtfc_pkg.sv
rtl/gtfc_flow.sv
rtl/gtf_mode_timing_calc_core.sv
test/tb_gtf_mode_timing_calc_core.sv
